/* rtl/core/depth_window_feature_check_assert.svh */
// assertion macros shared by the checker
`ifndef DEPTH_WINDOW_FEATURE_CHECK_ASSERT_SVH
`define DEPTH_WINDOW_FEATURE_CHECK_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define DWFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dwfc assertion failed");

// next-cycle implication
`define DWFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dwfc assertion failed");

`endif

/* rtl/core/dwfc_pkg.sv */
package dwfc_pkg;

  localparam int XW   = 10;  // pos_x width
  localparam int YW   = 9;   // pos_y width
  localparam int BW   = 8;   // depth byte width
  localparam int DW   = 16;  // depth width
  localparam int RADW = 3;   // window_radius register width
  localparam int RIW  = 1;   // register index width
  localparam int CW   = 14;  // signed window coordinate width
  localparam int RW   = 4;   // saturated radius width
  localparam int OW   = 5;   // window offset counter width

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  localparam logic [RIW-1:0] REG_WINDOW_RADIUS   = 1'b0;
  localparam logic [RIW-1:0] REG_MAX_DEPTH_DELTA = 1'b1;

  // one access to the pixel store, coordinates are two's complement
  typedef struct packed {
    logic          en;
    logic          we;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [DW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic          valid;
    logic          feature_valid;
    logic [DW-1:0] centre_depth;
  } result_t;

endpackage

/* rtl/core/depth_window_feature_check.sv */
// Depth frame store with a feature check. A write beat (func 0) stores
// the depth {depth_high_byte, depth_low_byte} at (pos_x, pos_y) and
// gives no result; writes outside the frame are dropped. A query beat (func 1)
// reads the centre depth and, for a nonzero window_radius (saturated to
// MAX_RADIUS), every pixel of the square window round it, one pixel a cycle
// through the single port of the frame memory; neighbours outside the frame
// count as zero. The feature is valid when the centre is nonzero and no
// nonzero neighbour differs from it by more than max_depth_delta. One query
// is worked on at a time; the next item is taken while the result waits in
// the output register. Pixels must be written before they are queried.
// The user must write configuration only while idle; the block itself does
// not enforce this.
module depth_window_feature_check #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480,
  parameter int MAX_RADIUS   = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwfc_pkg::RIW-1:0]      cfg_index_i,
  input  logic [dwfc_pkg::DW-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [dwfc_pkg::XW-1:0]       pos_x_i,
  input  logic [dwfc_pkg::YW-1:0]       pos_y_i,
  input  logic [dwfc_pkg::BW-1:0]       depth_high_byte_i,
  input  logic [dwfc_pkg::BW-1:0]       depth_low_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          feature_valid_o,
  output logic [dwfc_pkg::DW-1:0]       centre_depth_o
);

  localparam int CW = dwfc_pkg::CW;

  logic [dwfc_pkg::RADW-1:0] radius_q;
  logic [dwfc_pkg::DW-1:0]   delta_q;
  logic                      out_valid_q;
  logic                      feature_valid_q;
  logic [dwfc_pkg::DW-1:0]   centre_depth_q;

  logic                      busy;
  logic                      in_accept;
  logic                      wr_accept;
  logic                      query_start;
  logic                      out_load;
  dwfc_pkg::mem_req_t        scan_req;
  dwfc_pkg::mem_req_t        mem_req;
  dwfc_pkg::result_t         result;
  logic [dwfc_pkg::DW-1:0]   rdata;

  assign in_stall_o  = busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign wr_accept   = in_accept && (func_i == dwfc_pkg::FUNC_WRITE);
  assign query_start = in_accept && (func_i == dwfc_pkg::FUNC_QUERY);
  assign out_load    = result.valid && (!out_valid_q || !out_stall_i);

  // writes only arrive while the scan is idle, so the port is never contended
  always_comb begin
    if (wr_accept) begin
      mem_req.en    = 1'b1;
      mem_req.we    = 1'b1;
      mem_req.x     = CW'(pos_x_i);
      mem_req.y     = CW'(pos_y_i);
      mem_req.wdata = {depth_high_byte_i, depth_low_byte_i};
    end else begin
      mem_req = scan_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      delta_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dwfc_pkg::REG_WINDOW_RADIUS:   radius_q <= cfg_wdata_i[dwfc_pkg::RADW-1:0];
        dwfc_pkg::REG_MAX_DEPTH_DELTA: delta_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      feature_valid_q <= result.feature_valid;
      centre_depth_q  <= result.centre_depth;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign feature_valid_o = feature_valid_q;
  assign centre_depth_o  = centre_depth_q;

  dwfc_scan #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (query_start),
    .cx_i       (pos_x_i),
    .cy_i       (pos_y_i),
    .radius_i   (radius_q),
    .delta_i    (delta_q),
    .rdata_i    (rdata),
    .res_taken_i(out_load),
    .req_o      (scan_req),
    .res_o      (result),
    .busy_o     (busy)
  );

  dwfc_store #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rdata)
  );

endmodule

/* rtl/core/dwfc_store.sv */
module dwfc_store #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dwfc_pkg::mem_req_t          req_i,
  output logic [dwfc_pkg::DW-1:0]     rdata_o
);

  localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = dwfc_pkg::CW;

  logic [dwfc_pkg::DW-1:0] mem_q [Depth];
  logic [dwfc_pkg::DW-1:0] rdata_q;
  logic                    hit_q;
  logic                    in_frame;
  logic [AW-1:0]           addr;

  always_comb begin
    in_frame = !req_i.x[CW-1] && !req_i.y[CW-1] &&
               (req_i.x < CW'(FRAME_WIDTH)) && (req_i.y < CW'(FRAME_HEIGHT));
    addr = AW'(req_i.y[CW-2:0]) * AW'(FRAME_WIDTH) + AW'(req_i.x[CW-2:0]);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we && in_frame) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.en && !req_i.we && in_frame) begin
      rdata_q <= mem_q[addr];
    end
  end

  // pixels outside the frame read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (req_i.en && !req_i.we) begin
      hit_q <= in_frame;
    end
  end

  assign rdata_o = hit_q ? rdata_q : '0;

endmodule

/* rtl/core/dwfc_scan.sv */
module dwfc_scan #(
  parameter int MAX_RADIUS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dwfc_pkg::XW-1:0]       cx_i,
  input  logic [dwfc_pkg::YW-1:0]       cy_i,
  input  logic [dwfc_pkg::RADW-1:0]     radius_i,
  input  logic [dwfc_pkg::DW-1:0]       delta_i,
  input  logic [dwfc_pkg::DW-1:0]       rdata_i,
  input  logic                          res_taken_i,
  output dwfc_pkg::mem_req_t            req_o,
  output dwfc_pkg::result_t             res_o,
  output logic                          busy_o
);

  localparam int CW = dwfc_pkg::CW;
  localparam int RW = dwfc_pkg::RW;
  localparam int OW = dwfc_pkg::OW;
  localparam int DW = dwfc_pkg::DW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CENTRE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [dwfc_pkg::XW-1:0] cx_q;
  logic [dwfc_pkg::YW-1:0] cy_q;
  logic [RW-1:0]           r_q;
  logic [DW-1:0]           delta_q;
  logic [DW-1:0]           centre_q;
  logic [OW-1:0]           row_q;
  logic [OW-1:0]           col_q;
  logic                    pend_q;
  logic                    ok_q;

  logic [RW-1:0]           r_sat;
  logic [OW-1:0]           span;
  logic signed [CW-1:0]    nx;
  logic signed [CW-1:0]    ny;
  logic [DW-1:0]           diff;
  logic                    fail;

  always_comb begin
    r_sat = (radius_i > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_i);
    span  = {r_q, 1'b0};
    nx    = CW'(cx_q) + CW'(col_q) - CW'(r_q);
    ny    = CW'(cy_q) + CW'(row_q) - CW'(r_q);
    diff  = (rdata_i > centre_q) ? (rdata_i - centre_q) : (centre_q - rdata_i);
    // the previous window read is compared while the next one is issued
    fail  = pend_q && (rdata_i != '0) && (diff > delta_q);
  end

  always_comb begin
    req_o       = '0;
    req_o.we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_o.en = start_i;
        req_o.x  = CW'(cx_i);
        req_o.y  = CW'(cy_i);
      end
      S_SCAN: begin
        req_o.en = 1'b1;
        req_o.x  = nx;
        req_o.y  = ny;
      end
      default: req_o.en = 1'b0;
    endcase
    res_o.valid         = (state_q == S_DONE);
    res_o.feature_valid = ok_q;
    res_o.centre_depth  = centre_q;
    busy_o              = (state_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cx_q     <= '0;
      cy_q     <= '0;
      r_q      <= '0;
      delta_q  <= '0;
      centre_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      pend_q   <= 1'b0;
      ok_q     <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (start_i) begin
            cx_q    <= cx_i;
            cy_q    <= cy_i;
            r_q     <= r_sat;
            delta_q <= delta_i;
            state_q <= S_CENTRE;
          end
        end
        S_CENTRE: begin
          centre_q <= rdata_i;
          ok_q     <= (rdata_i != '0);
          row_q    <= '0;
          col_q    <= '0;
          if ((rdata_i == '0) || (r_q == '0)) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q <= 1'b1;
          if (fail) begin
            ok_q <= 1'b0;
          end
          if (col_q == span) begin
            col_q <= '0;
            row_q <= row_q + OW'(1);
            if (row_q == span) begin
              state_q <= S_LAST;
            end
          end else begin
            col_q <= col_q + OW'(1);
          end
        end
        S_LAST: begin
          pend_q <= 1'b0;
          if (fail) begin
            ok_q <= 1'b0;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_taken_i) begin
            ok_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/dwfc_checker.sv */
`include "depth_window_feature_check_assert.svh"

module dwfc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        func_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        feature_valid_o,
  input logic [dwfc_pkg::DW-1:0]     centre_depth_o
);

  // a stalled result beat holds
`DWFC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(centre_depth_o) && $stable(feature_valid_o))

  // a valid feature always has depth
`DWFC_ASSERT_IMP(a_valid_has_depth, out_valid_o && feature_valid_o, centre_depth_o != '0)

  // a query keeps the input side busy while the window is scanned
`DWFC_ASSERT_NXT(a_query_busy, in_valid_i && !in_stall_o && func_i == dwfc_pkg::FUNC_QUERY, in_stall_o)

  // a write beat leaves the input side free for the next beat
`DWFC_ASSERT_NXT(a_write_free, in_valid_i && !in_stall_o && func_i == dwfc_pkg::FUNC_WRITE, !in_stall_o)

endmodule

bind depth_window_feature_check dwfc_checker u_dwfc_checker (.*);
